/* hw/rtl/rcs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared constants for the rod cut solution engine: field widths, command
// codes and parameter defaults.
// ----------------------------------------------------------------------------
package rcs_pkg;

  // item field widths
  localparam int PRICE_LEN_W = 4;
  localparam int PRICE_W     = 16;
  localparam int ROD_W       = 7;
  localparam int TOTAL_W     = 22;
  localparam int PIECE_W     = 7;

  // command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  // parameter defaults
  localparam int PRICE_COUNT_DEF = 10;
  localparam int MAX_LENGTH_DEF  = 64;

  // result limit per solve and its counter width
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic [TOTAL_W-1:0] REVENUE_MAX = {TOTAL_W{1'b1}};

endpackage

`default_nettype wire

/* hw/rtl/rcs_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcs_mem
// Table memory for best revenue and first cut per length. One write port,
// one read port with registered read data.
// ----------------------------------------------------------------------------
module rcs_mem #(
  parameter int DEPTH = 65,
  parameter int AW    = 7,
  parameter int DW    = 30
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/rcs_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcs_step
// Shared compare-add unit: price of a first cut plus the best revenue of the
// remainder, kept when it is the first cut tried or strictly better than the
// running best.
module rcs_step #(
  parameter int LW = 7,
  parameter int RW = 23
) (
  input  wire logic [rcs_pkg::PRICE_W-1:0] price,
  input  wire logic [RW-1:0]               base,
  input  wire logic [LW-1:0]               try_cut,
  input  wire logic                        first,
  input  wire logic [RW-1:0]               cur_best,
  input  wire logic [LW-1:0]               cur_cut,
  output logic      [RW-1:0]               nxt_best,
  output logic      [LW-1:0]               nxt_cut
);

  logic [RW-1:0] sum;

  assign sum = RW'(price) + base;

  always_comb begin
    if (first || (sum > cur_best)) begin
      nxt_best = sum;
      nxt_cut  = try_cut;
    end else begin
      nxt_best = cur_best;
      nxt_cut  = cur_cut;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rod_cut_solution_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rod_cut_solution_engine
// Rod cutting by bottom-up dynamic programming over a shared compare-add unit.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): command 0 loads price_value for piece
// length price_length (lengths outside 1..PRICE_COUNT are dropped); command 1
// solves for rod_length (saturated to MAX_LENGTH).
// Output channel (out_valid/out_stall): one item per cut piece, in walk order,
// each carrying the total revenue; last_piece marks the final piece. An empty
// rod gives one item with piece_length 0.
// A solve for length n fills the tables first (one compare-add per cycle in
// the shared unit, and a write of each length's best in a drain state), then
// walks them piece by piece through read, wait and emit states. in_stall
// stays high for the whole solve; the last piece sits in the output register
// while the next item is taken. A stalled output holds; the walk waits for
// the output register.
// Reset clears the price store and control state; the tables need no clear
// since each solve writes every entry before reading it.
// ----------------------------------------------------------------------------
module rod_cut_solution_engine #(
  parameter int PRICE_COUNT = rcs_pkg::PRICE_COUNT_DEF,
  parameter int MAX_LENGTH  = rcs_pkg::MAX_LENGTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            command,
  input  wire logic [rcs_pkg::PRICE_LEN_W-1:0] price_length,
  input  wire logic [rcs_pkg::PRICE_W-1:0]     price_value,
  input  wire logic [rcs_pkg::ROD_W-1:0]       rod_length,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [rcs_pkg::TOTAL_W-1:0]     total_revenue,
  output logic      [rcs_pkg::PIECE_W-1:0]     piece_length,
  output logic                                 last_piece
);

  localparam int AW     = $clog2(MAX_LENGTH + 1);
  localparam int LW     = (AW > rcs_pkg::ROD_W) ? AW : rcs_pkg::ROD_W;
  localparam int RW_RAW = rcs_pkg::PRICE_W + AW;
  localparam int RW     = (RW_RAW > rcs_pkg::TOTAL_W) ? RW_RAW : rcs_pkg::TOTAL_W + 1;
  localparam int DW     = RW + LW;
  localparam int CW     = rcs_pkg::CNT_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INIT    = 3'd1;
  localparam logic [2:0] S_INNER   = 3'd2;
  localparam logic [2:0] S_DRAIN   = 3'd3;
  localparam logic [2:0] S_WALK_RD = 3'd4;
  localparam logic [2:0] S_WALK_WT = 3'd5;
  localparam logic [2:0] S_EMIT    = 3'd6;

  logic [2:0]    state;
  logic [LW-1:0] n;
  logic [LW-1:0] j;
  logic [LW-1:0] i;
  logic [LW-1:0] i_d;
  logic          pend;
  logic [RW-1:0] best;
  logic [LW-1:0] cut;
  logic [RW-1:0] total;
  logic [LW-1:0] n_rem;
  logic [CW-1:0] cnt;
  logic [LW-1:0] piece;
  logic          last;

  logic [rcs_pkg::PRICE_W-1:0] price_store [PRICE_COUNT];

  logic                        accept;
  logic                        load_en;
  logic [LW-1:0]               rod_ext;
  logic [LW-1:0]               rod_sat;
  logic [rcs_pkg::PRICE_W-1:0] price_sel;
  logic [RW-1:0]               nxt_best;
  logic [LW-1:0]               nxt_cut;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [DW-1:0]               mem_wdata;
  logic [AW-1:0]               mem_raddr;
  logic [DW-1:0]               mem_rdata;
  logic [RW-1:0]               rd_best;
  logic [LW-1:0]               rd_cut;
  logic [LW-1:0]               walk_cut;
  logic                        out_free;
  logic [LW-1:0]               sub_addr;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_en  = accept && (command == rcs_pkg::CMD_LOAD);
  assign out_free = !out_valid || !out_stall;

  assign rod_ext = LW'(rod_length);
  assign rod_sat = (rod_ext > LW'(MAX_LENGTH)) ? LW'(MAX_LENGTH) : rod_ext;

  // price of the cut under test; lengths past the store earn nothing
  always_comb begin
    price_sel = '0;
    for (int k = 0; k < PRICE_COUNT; k++) begin
      if (i_d == LW'(k + 1)) begin
        price_sel = price_store[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PRICE_COUNT; k++) begin
        price_store[k] <= '0;
      end
    end else if (load_en) begin
      for (int k = 0; k < PRICE_COUNT; k++) begin
        if (32'(price_length) == k + 1) begin
          price_store[k] <= price_value;
        end
      end
    end
  end

  assign rd_best = mem_rdata[DW-1:LW];
  assign rd_cut  = mem_rdata[LW-1:0];

  rcs_step #(
    .LW (LW),
    .RW (RW)
  ) u_step (
    .price    (price_sel),
    .base     (rd_best),
    .try_cut  (i_d),
    .first    (i_d == LW'(1)),
    .cur_best (best),
    .cur_cut  (cut),
    .nxt_best (nxt_best),
    .nxt_cut  (nxt_cut)
  );

  assign sub_addr  = j - i;
  assign mem_we    = (state == S_INIT) || (state == S_DRAIN);
  assign mem_waddr = (state == S_INIT) ? '0 : j[AW-1:0];
  assign mem_wdata = (state == S_INIT) ? '0 : {nxt_best, nxt_cut};
  assign mem_raddr = (state == S_INNER) ? sub_addr[AW-1:0] : n_rem[AW-1:0];

  rcs_mem #(
    .DEPTH (MAX_LENGTH + 1),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // guard against a table entry that does not fit the remaining rod
  assign walk_cut = ((rd_cut == '0) || (rd_cut > n_rem)) ? n_rem : rd_cut;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (command == rcs_pkg::CMD_SOLVE)) begin
            n     <= rod_sat;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          pend <= 1'b0;
          cnt  <= '0;
          if (n == '0) begin
            total <= '0;
            piece <= '0;
            last  <= 1'b1;
            state <= S_EMIT;
          end else begin
            j     <= LW'(1);
            i     <= LW'(1);
            state <= S_INNER;
          end
        end
        S_INNER: begin
          pend <= 1'b1;
          i_d  <= i;
          if (pend) begin
            best <= nxt_best;
            cut  <= nxt_cut;
          end
          if (i == j) begin
            state <= S_DRAIN;
          end else begin
            i <= i + LW'(1);
          end
        end
        S_DRAIN: begin
          pend <= 1'b0;
          if (j == n) begin
            total <= nxt_best;
            n_rem <= n;
            state <= S_WALK_RD;
          end else begin
            j     <= j + LW'(1);
            i     <= LW'(1);
            state <= S_INNER;
          end
        end
        S_WALK_RD: begin
          state <= S_WALK_WT;
        end
        S_WALK_WT: begin
          piece <= walk_cut;
          last  <= (walk_cut == n_rem);
          n_rem <= n_rem - walk_cut;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            cnt <= cnt + CW'(1);
            if (last || (cnt == CW'(rcs_pkg::MAX_RESULTS - 1))) begin
              state <= S_IDLE;
            end else begin
              state <= S_WALK_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      total_revenue <= (total > RW'(rcs_pkg::REVENUE_MAX)) ? rcs_pkg::REVENUE_MAX
                                                           : total[rcs_pkg::TOTAL_W-1:0];
      piece_length  <= piece[rcs_pkg::PIECE_W-1:0];
      last_piece    <= last;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rcs_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rcs_checker
// Port-level checks for the rod cut solution engine, bound to the top level.
// ----------------------------------------------------------------------------
module rcs_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_stall,
  input wire logic                            command,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [rcs_pkg::TOTAL_W-1:0]     total_revenue,
  input wire logic [rcs_pkg::PIECE_W-1:0]     piece_length,
  input wire logic                            last_piece
);

  // a solve keeps the input side busy in the following cycle
  a_solve_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (command == rcs_pkg::CMD_SOLVE) |=> in_stall)
    else $error("input taken right after a solve item");

  // a load never produces an item
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (command == rcs_pkg::CMD_LOAD) && !out_valid
    |=> !out_valid)
    else $error("load item produced an output item");

  // a zero-length piece only comes from an empty rod
  a_empty_rod: assert property (@(posedge clk) disable iff (rst)
    out_valid && (piece_length == '0) |-> (total_revenue == '0) && last_piece)
    else $error("zero piece with revenue or more pieces");

  // stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(total_revenue)
      && $stable(piece_length) && $stable(last_piece))
    else $error("stalled output item changed");

endmodule

bind rod_cut_solution_engine rcs_checker u_rcs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .command       (command),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .total_revenue (total_revenue),
  .piece_length  (piece_length),
  .last_piece    (last_piece)
);

`default_nettype wire
